### hdl/mbsd_pkg.sv
// Shared types and constants for the MIDI byte stream decoder.
// No dependencies; imported by every module of the block.
package mbsd_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [3:0] HI_PROGRAM     = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;

    localparam logic [2:0] KIND_BEND      = 3'd6;
    localparam logic [2:0] KIND_SYSEX     = 3'd7;

    // offset-binary to two's complement for the 14-bit bend word
    localparam logic [13:0] BEND_FLIP     = 14'h2000;

    typedef struct packed {
        logic              is_sysex;
        logic [2:0]        kind;
        logic [3:0]        channel;
        logic [6:0]        p1;
        logic [6:0]        p2;
        logic [13:0]       bend;
        logic [CNT_W-1:0]  cnt;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

endpackage

### hdl/mbsd_front.sv
// Front end: accepts words, tracks the message parser state and classifies bytes.
// Pushes finished messages to the queue and writes sysex bytes to the store. Uses mbsd_pkg.
module mbsd_front import mbsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd,
    output store_wr_t   st_wr,
    input  logic        drain_done
);

    logic             synced_reg, synced_next;
    logic             in_msg_reg, in_msg_next;
    logic [7:0]       status_reg, status_next;
    logic [1:0]       rem_reg, rem_next;
    logic [6:0]       first_reg, first_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             busy_reg, busy_next;

    logic             accept;
    logic [7:0]       b;
    logic [CNT_W-1:0] fill_inc;
    logic [3:0]       hi;
    logic [13:0]      bend_raw;

    assign s_ready  = !q_full && !busy_reg;
    assign accept   = s_valid && s_ready;
    assign b        = s_rx_byte;
    assign fill_inc = fill_reg + CNT_W'(1);
    assign hi       = status_reg[7:4];

    always_comb begin
        synced_next = synced_reg;
        in_msg_next = in_msg_reg;
        status_next = status_reg;
        rem_next    = rem_reg;
        first_next  = first_reg;
        fill_next   = fill_reg;
        busy_next   = busy_reg && !drain_done;
        q_push      = 1'b0;
        q_cmd       = '0;
        st_wr.en    = 1'b0;
        st_wr.addr  = fill_reg[ADDR_W-1:0];
        st_wr.data  = b;
        bend_raw    = '0;

        if (accept) begin
            if (b[7]) begin
                if (b == ST_SYSEX_END) begin
                    if (in_msg_reg) begin
                        if (status_reg == ST_SYSEX_START) begin
                            st_wr.en     = 1'b1;
                            q_push       = 1'b1;
                            q_cmd.is_sysex = 1'b1;
                            q_cmd.kind   = KIND_SYSEX;
                            q_cmd.cnt    = fill_inc;
                            fill_next    = '0;
                            busy_next    = 1'b1;
                        end
                        in_msg_next = 1'b0;
                        rem_next    = '0;
                    end
                end else begin
                    synced_next = 1'b1;
                    in_msg_next = 1'b0;
                    rem_next    = '0;
                    fill_next   = '0;
                    if (b < ST_SYSEX_START) begin
                        status_next = b;
                        in_msg_next = 1'b1;
                        rem_next    = (b[7:4] == HI_PROGRAM || b[7:4] == HI_CHAN_PRESS)
                                      ? 2'd1 : 2'd2;
                    end else if (b == ST_SYSEX_START) begin
                        status_next = b;
                        in_msg_next = 1'b1;
                        st_wr.en    = 1'b1;
                        st_wr.addr  = '0;
                        fill_next   = CNT_W'(1);
                    end
                end
            end else if (synced_reg && in_msg_reg) begin
                if (status_reg == ST_SYSEX_START) begin
                    st_wr.en  = 1'b1;
                    fill_next = fill_inc;
                    // store full without an end byte: flush what is held
                    if (fill_inc >= CNT_W'(BUF_DEPTH)) begin
                        q_push         = 1'b1;
                        q_cmd.is_sysex = 1'b1;
                        q_cmd.kind     = KIND_SYSEX;
                        q_cmd.cnt      = fill_inc;
                        fill_next      = '0;
                        in_msg_next    = 1'b0;
                        busy_next      = 1'b1;
                    end
                end else if (rem_reg >= 2'd2) begin
                    first_next = b[6:0];
                    rem_next   = 2'd1;
                end else begin
                    q_push        = 1'b1;
                    q_cmd.kind    = status_reg[6:4];
                    q_cmd.channel = status_reg[3:0];
                    if (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) begin
                        q_cmd.p1 = b[6:0];
                        q_cmd.p2 = '0;
                    end else begin
                        q_cmd.p1 = first_reg;
                        q_cmd.p2 = b[6:0];
                    end
                    bend_raw = {b[6:0], first_reg};
                    if (status_reg[6:4] == KIND_BEND) begin
                        q_cmd.bend = bend_raw ^ BEND_FLIP;
                    end
                    in_msg_next = 1'b0;
                    rem_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg <= 1'b0;
            in_msg_reg <= 1'b0;
            status_reg <= '0;
            rem_reg    <= '0;
            first_reg  <= '0;
            fill_reg   <= '0;
            busy_reg   <= 1'b0;
        end else begin
            synced_reg <= synced_next;
            in_msg_reg <= in_msg_next;
            status_reg <= status_next;
            rem_reg    <= rem_next;
            first_reg  <= first_next;
            fill_reg   <= fill_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

### hdl/mbsd_queue.sv
// Short command queue between the front end and the back end.
// Holds cmd_t entries from mbsd_pkg.
module mbsd_queue import mbsd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t            q_mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + (Q_AW+1)'(1);
            2'b01:   cnt_next = cnt_reg - (Q_AW+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/mbsd_back.sv
// Back end: pops commands, holds the sysex store and drives the output register.
// Channel commands go straight out; sysex commands drain the store. Uses mbsd_pkg.
module mbsd_back import mbsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  cmd_t               q_head,
    output logic               q_pop,
    input  store_wr_t          st_wr,
    output logic               drain_done,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [3:0]         m_channel,
    output logic [6:0]         m_first_param,
    output logic [6:0]         m_second_param,
    output logic signed [13:0] m_bend_value,
    output logic [7:0]         m_sysex_value,
    output logic               m_last
);

    localparam logic B_IDLE  = 1'b0;
    localparam logic B_DRAIN = 1'b1;

    logic [7:0]        store [BUF_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    logic              out_free;
    logic              load_chan;
    logic              load_sx;
    logic              sx_last;

    assign out_free = !m_valid_reg || m_ready;
    assign sx_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        load_chan    = 1'b0;
        load_sx      = 1'b0;
        drain_done   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    if (q_head.is_sysex) begin
                        q_pop      = 1'b1;
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        cnt_next   = q_head.cnt;
                        state_next = B_DRAIN;
                    end else if (out_free) begin
                        q_pop        = 1'b1;
                        load_chan    = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            B_DRAIN: begin
                // read data for idx_reg is in rd_data_reg this cycle
                if (out_free) begin
                    load_sx      = 1'b1;
                    m_valid_next = 1'b1;
                    if (sx_last) begin
                        drain_done = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_wr.en) begin
            store[st_wr.addr] <= st_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= store[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_chan) begin
            m_kind         <= q_head.kind;
            m_channel      <= q_head.channel;
            m_first_param  <= q_head.p1;
            m_second_param <= q_head.p2;
            m_bend_value   <= q_head.bend;
            m_sysex_value  <= '0;
            m_last         <= 1'b1;
        end else if (load_sx) begin
            m_kind         <= KIND_SYSEX;
            m_channel      <= '0;
            m_first_param  <= '0;
            m_second_param <= '0;
            m_bend_value   <= '0;
            m_sysex_value  <= rd_data_reg;
            m_last         <= sx_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/midi_byte_stream_decoder_core.sv
// Top level of the MIDI byte stream decoder: front end, command queue, back end.
// Depends on mbsd_pkg, mbsd_front, mbsd_queue and mbsd_back.
//
// Takes one received MIDI byte per word on s_ and gives decoded results on m_. A byte is
// taken every cycle while the command queue has room and no sysex drain is running; a
// complete channel message gives one result, pushed into the command queue once its last
// data byte is accepted and then loaded into the output register when that is free. A sysex
// message (F0 up to F7, or BUF_DEPTH bytes without F7) is held in a store inside the back
// end; once it ends, s_ready stays low until the last of its stored bytes is loaded into the
// output register. Store reads are registered, one per cycle while the output register is
// free, and set the drain rate. No clearing pass is needed after reset.
module midi_byte_stream_decoder_core import mbsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_valid,
    output logic               s_ready,
    output logic [2:0]         m_kind,
    output logic [3:0]         m_channel,
    output logic [6:0]         m_first_param,
    output logic [6:0]         m_second_param,
    output logic signed [13:0] m_bend_value,
    output logic [7:0]         m_sysex_value,
    output logic               m_last,
    output logic               m_valid,
    input  logic               m_ready
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    cmd_t      q_cmd;
    cmd_t      q_head;
    store_wr_t st_wr;
    logic      drain_done;

    mbsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_rx_byte  (s_rx_byte),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd),
        .st_wr      (st_wr),
        .drain_done (drain_done)
    );

    mbsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    mbsd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .st_wr          (st_wr),
        .drain_done     (drain_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_channel      (m_channel),
        .m_first_param  (m_first_param),
        .m_second_param (m_second_param),
        .m_bend_value   (m_bend_value),
        .m_sysex_value  (m_sysex_value),
        .m_last         (m_last)
    );

endmodule

### hdl/mbsd_checker.sv
// Port-level checker for the MIDI byte stream decoder, bound to the top level.
// Depends on mbsd_pkg and midi_byte_stream_decoder_core.
module mbsd_checker import mbsd_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_kind,
    input logic [3:0]         m_channel,
    input logic [6:0]         m_first_param,
    input logic [6:0]         m_second_param,
    input logic signed [13:0] m_bend_value,
    input logic [7:0]         m_sysex_value,
    input logic               m_last
);

    // a stalled result word stays valid and holds its kind, sysex value and last flag
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_sysex_value)
            && $stable(m_last))
        else $error("result word changed while stalled");

    a_chan_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_SYSEX |-> m_last && m_sysex_value == '0)
        else $error("channel message not single and final");

    a_bend_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_BEND |-> m_bend_value == '0)
        else $error("bend value on non-bend result");

    a_sysex_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_SYSEX |-> m_channel == '0 && m_first_param == '0
            && m_second_param == '0)
        else $error("channel fields set on sysex word");

endmodule

bind midi_byte_stream_decoder_core mbsd_checker u_mbsd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_channel      (m_channel),
    .m_first_param  (m_first_param),
    .m_second_param (m_second_param),
    .m_bend_value   (m_bend_value),
    .m_sysex_value  (m_sysex_value),
    .m_last         (m_last)
);

### test/midi_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the MIDI byte stream decoder: decodes every accepted input word
// in parallel with the block and compares each delivered result word field by field.
// Depends on mbsd_pkg for the status codes, kinds and BUF_DEPTH.
module midi_result_checker import mbsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [2:0]         m_kind,
    input  logic [3:0]         m_channel,
    input  logic [6:0]         m_first_param,
    input  logic [6:0]         m_second_param,
    input  logic signed [13:0] m_bend_value,
    input  logic [7:0]         m_sysex_value,
    input  logic               m_last,
    input  logic               m_valid,
    input  logic               m_ready,
    output int                 mismatch_count,
    output int                 pending_results
);

    typedef struct {
        logic [2:0]         kind;
        logic [3:0]         channel;
        logic [6:0]         param1;
        logic [6:0]         param2;
        logic signed [13:0] bend;
        logic [7:0]         sysex;
        logic               last;
    } midi_result_t;

    midi_result_t expected_results[$];

    // decoder state, mirrors what the block keeps
    logic       synced      = 1'b0;
    logic       msg_open    = 1'b0;
    logic [7:0] held_status = 8'h00;
    int         data_left   = 0;
    logic [6:0] first_byte  = 7'h00;
    int         fill_cnt    = 0;
    logic [7:0] sysex_buf [BUF_DEPTH];

    task automatic queue_channel_result(input logic [6:0] p1, input logic [6:0] p2);
        midi_result_t r;
        r.kind    = held_status[6:4];
        r.channel = held_status[3:0];
        r.param1  = p1;
        r.param2  = p2;
        // 14-bit offset binary to signed: wraps modulo 2^14
        r.bend    = (r.kind == KIND_BEND) ? ({p2, p1} - 14'd8192) : 14'sd0;
        r.sysex   = 8'h00;
        r.last    = 1'b1;
        expected_results.push_back(r);
        msg_open  = 1'b0;
        data_left = 0;
    endtask

    task automatic queue_sysex_results();
        midi_result_t r;
        int n;
        n = (fill_cnt > BUF_DEPTH) ? BUF_DEPTH : fill_cnt;
        for (int i = 0; i < n; i++) begin
            r.kind    = KIND_SYSEX;
            r.channel = 4'h0;
            r.param1  = 7'h00;
            r.param2  = 7'h00;
            r.bend    = 14'sd0;
            r.sysex   = sysex_buf[i];
            r.last    = (i + 1 == n);
            expected_results.push_back(r);
        end
        msg_open = 1'b0;
        fill_cnt = 0;
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        logic one_data;
        one_data = (held_status[7:4] == HI_PROGRAM) || (held_status[7:4] == HI_CHAN_PRESS);
        if (b[7]) begin
            if (b == ST_SYSEX_END) begin
                if (!msg_open)
                    return;
                if (held_status == ST_SYSEX_START) begin
                    if (fill_cnt < BUF_DEPTH) begin
                        sysex_buf[fill_cnt] = b;
                        fill_cnt++;
                    end
                    queue_sysex_results();
                end else begin
                    // early end mark aborts a channel message silently
                    msg_open  = 1'b0;
                    data_left = 0;
                end
                return;
            end
            synced    = 1'b1;
            msg_open  = 1'b0;
            data_left = 0;
            fill_cnt  = 0;
            if (b < ST_SYSEX_START) begin
                held_status = b;
                msg_open    = 1'b1;
                data_left   = (b[7:4] == HI_PROGRAM || b[7:4] == HI_CHAN_PRESS) ? 1 : 2;
            end else if (b == ST_SYSEX_START) begin
                held_status  = b;
                msg_open     = 1'b1;
                sysex_buf[0] = b;
                fill_cnt     = 1;
            end
            return;
        end
        if (!synced || !msg_open)
            return;
        if (held_status == ST_SYSEX_START) begin
            if (fill_cnt < BUF_DEPTH) begin
                sysex_buf[fill_cnt] = b;
                fill_cnt++;
            end
            if (fill_cnt >= BUF_DEPTH)
                queue_sysex_results();
            return;
        end
        if (data_left >= 2) begin
            first_byte = b[6:0];
            data_left  = 1;
            return;
        end
        if (one_data)
            queue_channel_result(b[6:0], 7'h00);
        else
            queue_channel_result(first_byte, b[6:0]);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        midi_result_t want;
        if (!aresetn) begin
            synced      = 1'b0;
            msg_open    = 1'b0;
            held_status = 8'h00;
            data_left   = 0;
            first_byte  = 7'h00;
            fill_cnt    = 0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready)
                decode_rx_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected (kind %0d)", m_kind);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind",         want.kind,    m_kind);
                    check_field("channel",      want.channel, m_channel);
                    check_field("first_param",  want.param1,  m_first_param);
                    check_field("second_param", want.param2,  m_second_param);
                    check_field("bend_value",   int'(want.bend), int'(m_bend_value));
                    check_field("sysex_value",  want.sysex,   m_sysex_value);
                    check_field("last",         want.last,    m_last);
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Top of the MIDI byte stream decoder testbench: clock, reset, byte stream and
// receiver stalls. Depends on mbsd_pkg, midi_byte_stream_decoder_core, midi_result_checker.
module tb_top import mbsd_pkg::*; ();

    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
    localparam logic [7:0] ST_CONTROL    = 8'hB0;
    localparam logic [7:0] ST_PROGRAM    = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] ST_BEND       = 8'hE0;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_SYS_FIRST  = 8'hF1;
    localparam logic [7:0] ST_LAST_CHAN  = 8'hEF;
    localparam logic [7:0] ST_RESET      = 8'hFF;

    localparam int RANDOM_WORDS = 175;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [2:0]         m_kind;
    logic [3:0]         m_channel;
    logic [6:0]         m_first_param;
    logic [6:0]         m_second_param;
    logic signed [13:0] m_bend_value;
    logic [7:0]         m_sysex_value;
    logic               m_last;
    logic               m_valid;
    logic               m_ready   = 1'b0;

    int mismatch_count;
    int pending_results;
    int sent_cnt = 0;
    int cycle_cnt = 0;

    logic [7:0] stream_q[$];

    always #10 aclk = ~aclk;

    midi_byte_stream_decoder_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_rx_byte      (s_rx_byte),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_kind         (m_kind),
        .m_channel      (m_channel),
        .m_first_param  (m_first_param),
        .m_second_param (m_second_param),
        .m_bend_value   (m_bend_value),
        .m_sysex_value  (m_sysex_value),
        .m_last         (m_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

    midi_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_rx_byte       (s_rx_byte),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_kind          (m_kind),
        .m_channel       (m_channel),
        .m_first_param   (m_first_param),
        .m_second_param  (m_second_param),
        .m_bend_value    (m_bend_value),
        .m_sysex_value   (m_sysex_value),
        .m_last          (m_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] rand_status();
        return 8'($urandom_range(ST_NOTE_OFF, ST_LAST_CHAN));
    endfunction

    task automatic add_sysex(input int n_data, input bit closed);
        stream_q.push_back(ST_SYSEX_START);
        repeat (n_data) stream_q.push_back(rand_data());
        if (closed)
            stream_q.push_back(ST_SYSEX_END);
    endtask

    task automatic add_random_message();
        logic [7:0] st;
        int pick;
        pick = $urandom_range(0, 99);
        st   = rand_status();
        if (pick < 60) begin
            stream_q.push_back(st);
            stream_q.push_back(rand_data());
            if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CHAN_PRESS)
                stream_q.push_back(rand_data());
        end else if (pick < 75) begin
            // mostly short sysex, now and then a long one that can run into a full buffer
            if ($urandom_range(0, 7) == 0)
                add_sysex($urandom_range(60, 66), $urandom_range(0, 3) != 0);
            else
                add_sysex($urandom_range(0, 10), $urandom_range(0, 3) != 0);
        end else begin
            case ($urandom_range(0, 3))
                0: stream_q.push_back(8'($urandom_range(0, 255)));
                1: stream_q.push_back(8'($urandom_range(ST_SYS_FIRST, ST_RESET)));
                2: begin
                    // status and at most one data byte: truncated for most kinds; the next status abandons it
                    stream_q.push_back(st);
                    if ($urandom_range(0, 1)) stream_q.push_back(rand_data());
                end
                default: begin
                    stream_q.push_back(st);
                    if ($urandom_range(0, 1)) stream_q.push_back(rand_data());
                    stream_q.push_back(ST_SYSEX_END);
                end
            endcase
        end
    endtask

    // receiver: stretches of full speed, random and sparse ready, plus one long hold-off
    int  ready_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(8, 64);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int idx;
        int burst_left;
        int gap;
        int base;

        // before sync, then every channel kind, some at extreme values and some cut short
        stream_q = '{8'h45, 8'h00, ST_SYSEX_END,
                     ST_NOTE_ON, 8'h7F, 8'h7F,
                     ST_NOTE_OFF | 8'h0F, 8'h00, 8'h00,
                     ST_BEND, 8'h00, 8'h00,
                     ST_BEND | 8'h05, 8'h7F, 8'h7F,
                     ST_PROGRAM | 8'h03, 8'h55,
                     ST_CHAN_PRESS | 8'h07, 8'h2A,
                     ST_CONTROL | 8'h02, 8'h05, ST_CLOCK, 8'h40,
                     ST_POLY_PRESS | 8'h01, 8'h10, ST_SYSEX_END,
                     ST_NOTE_ON | 8'h02, 8'h3C, ST_NOTE_OFF | 8'h05, 8'h01, 8'h02};
        add_sysex(2, 1'b1);
        stream_q.push_back(ST_SYSEX_END);

        // random part: one sysex that fills the buffer, then a mix
        base = stream_q.size();
        add_sysex(BUF_DEPTH - 1, 1'b0);
        stream_q.push_back(ST_SYSEX_END);
        while (stream_q.size() - base < RANDOM_WORDS)
            add_random_message();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idx = 0;
        burst_left = 0;
        while (idx < stream_q.size()) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_rx_byte <= stream_q[idx];
            s_valid   <= 1'b1;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            idx++;
            burst_left--;
            sent_cnt++;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (pending_results == 0);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hdl/mbsd_pkg.sv
hdl/mbsd_front.sv
hdl/mbsd_queue.sv
hdl/mbsd_back.sv
hdl/midi_byte_stream_decoder_core.sv
hdl/mbsd_checker.sv
test/midi_result_checker.sv
test/tb_top.sv
